>>> hdl/calu_pkg.sv
// Shared types and constants for the 8-bit ALU with flags.
// Used by calu_core and cpu_8bit_alu_with_flags; no dependencies.

package calu_pkg;

	typedef enum logic [4:0] {
		ACT_ADD   = 5'd0,
		ACT_ADC   = 5'd1,
		ACT_SUB   = 5'd2,
		ACT_SBC   = 5'd3,
		ACT_AND   = 5'd4,
		ACT_XOR   = 5'd5,
		ACT_OR    = 5'd6,
		ACT_CP    = 5'd7,
		ACT_INC   = 5'd8,
		ACT_DEC   = 5'd9,
		ACT_DAA   = 5'd10,
		ACT_CPL   = 5'd11,
		ACT_SCF   = 5'd12,
		ACT_CCF   = 5'd13,
		ACT_RLCA  = 5'd14,
		ACT_RRCA  = 5'd15,
		ACT_RLA   = 5'd16,
		ACT_RRA   = 5'd17,
		ACT_RLC   = 5'd18,
		ACT_RRC   = 5'd19,
		ACT_RL    = 5'd20,
		ACT_RR    = 5'd21,
		ACT_SLA   = 5'd22,
		ACT_SRA   = 5'd23,
		ACT_SWAP  = 5'd24,
		ACT_SRL   = 5'd25,
		ACT_BIT   = 5'd26,
		ACT_RES   = 5'd27,
		ACT_SET   = 5'd28,
		ACT_ADD16 = 5'd29,
		ACT_ADDSP = 5'd30
	} alu_act_t;

	// flag bit positions
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	localparam logic [7:0] DAA_LIMIT   = 8'h99;
	localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
	localparam logic [3:0] DAA_LO_LIM  = 4'd9;

	typedef struct packed {
		logic [4:0]  action;
		logic [7:0]  accumulator;
		logic [15:0] operand;
		logic [15:0] base_word;
		logic [2:0]  bit_index;
		logic [3:0]  flags_in;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] result_value;
		logic [3:0]  flags_out;
		logic        writes_result;
	} alu_res_t;

endpackage

>>> hdl/calu_core.sv
// Combinational datapath of the ALU: adders, DAA, shifter and bit logic.
// Depends on calu_pkg for the request/result types and action codes.

module calu_core (
	input  calu_pkg::alu_req_t req,
	output calu_pkg::alu_res_t res
);

	calu_pkg::alu_act_t act;
	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;
	logic        zin;
	logic        nin;
	logic        hin;
	logic        add_t;
	logic        sub_t;
	logic [8:0]  add_sum;
	logic [4:0]  add_half;
	logic [8:0]  sub_diff;
	logic [4:0]  sub_half;
	logic        daa_c;
	logic [7:0]  daa_r1;
	logic [7:0]  daa_r2;
	logic [7:0]  sh_r;
	logic        sh_c;
	logic [7:0]  bit_mask;
	logic [16:0] w_sum;
	logic [12:0] w_half;
	logic [15:0] sp_ext;
	logic [15:0] sp_sum;
	logic [4:0]  sp_half;
	logic [8:0]  sp_carry;

	assign act = calu_pkg::alu_act_t'(req.action);
	assign a   = req.accumulator;
	assign b   = req.operand[7:0];
	assign cin = req.flags_in[calu_pkg::FLAG_C];
	assign zin = req.flags_in[calu_pkg::FLAG_Z];
	assign nin = req.flags_in[calu_pkg::FLAG_N];
	assign hin = req.flags_in[calu_pkg::FLAG_H];

	assign add_t    = (act == calu_pkg::ACT_ADC) ? cin : 1'b0;
	assign sub_t    = (act == calu_pkg::ACT_SBC) ? cin : 1'b0;
	assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, add_t};
	assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_t};
	// bit 8 / bit 4 of the difference is the borrow
	assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, sub_t};
	assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_t};

	always_comb begin
		if (!nin) begin
			daa_c  = cin || (a > calu_pkg::DAA_LIMIT);
			daa_r1 = daa_c ? (a + calu_pkg::DAA_HI_ADJ) : a;
			daa_r2 = (hin || (daa_r1[3:0] > calu_pkg::DAA_LO_LIM)) ?
				(daa_r1 + calu_pkg::DAA_LO_ADJ) : daa_r1;
		end else begin
			daa_c  = cin;
			daa_r1 = cin ? (a - calu_pkg::DAA_HI_ADJ) : a;
			daa_r2 = hin ? (daa_r1 - calu_pkg::DAA_LO_ADJ) : daa_r1;
		end
	end

	always_comb begin
		case (act)
			calu_pkg::ACT_RLC: begin
				sh_r = {b[6:0], b[7]};
				sh_c = b[7];
			end
			calu_pkg::ACT_RRC: begin
				sh_r = {b[0], b[7:1]};
				sh_c = b[0];
			end
			calu_pkg::ACT_RL: begin
				sh_r = {b[6:0], cin};
				sh_c = b[7];
			end
			calu_pkg::ACT_RR: begin
				sh_r = {cin, b[7:1]};
				sh_c = b[0];
			end
			calu_pkg::ACT_SLA: begin
				sh_r = {b[6:0], 1'b0};
				sh_c = b[7];
			end
			calu_pkg::ACT_SRA: begin
				sh_r = {b[7], b[7:1]};
				sh_c = b[0];
			end
			calu_pkg::ACT_SWAP: begin
				sh_r = {b[3:0], b[7:4]};
				sh_c = 1'b0;
			end
			default: begin
				sh_r = {1'b0, b[7:1]};
				sh_c = b[0];
			end
		endcase
	end

	assign bit_mask = 8'd1 << req.bit_index;
	assign w_sum    = {1'b0, req.base_word} + {1'b0, req.operand};
	assign w_half   = {1'b0, req.base_word[11:0]} + {1'b0, req.operand[11:0]};
	assign sp_ext   = {{8{b[7]}}, b};
	assign sp_sum   = req.base_word + sp_ext;
	assign sp_half  = {1'b0, req.base_word[3:0]} + {1'b0, b[3:0]};
	assign sp_carry = {1'b0, req.base_word[7:0]} + {1'b0, b};

	always_comb begin
		res.result_value  = 16'd0;
		res.flags_out     = req.flags_in;
		res.writes_result = 1'b1;
		case (act)
			calu_pkg::ACT_ADD, calu_pkg::ACT_ADC: begin
				res.result_value = {8'd0, add_sum[7:0]};
				res.flags_out = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
			end
			calu_pkg::ACT_SUB, calu_pkg::ACT_SBC, calu_pkg::ACT_CP: begin
				res.result_value = {8'd0, sub_diff[7:0]};
				res.flags_out = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
				if (act == calu_pkg::ACT_CP) begin
					res.result_value  = 16'd0;
					res.writes_result = 1'b0;
				end
			end
			calu_pkg::ACT_AND: begin
				res.result_value = {8'd0, a & b};
				res.flags_out = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			calu_pkg::ACT_XOR: begin
				res.result_value = {8'd0, a ^ b};
				res.flags_out = {(a ^ b) == 8'd0, 1'b0, 1'b0, 1'b0};
			end
			calu_pkg::ACT_OR: begin
				res.result_value = {8'd0, a | b};
				res.flags_out = {(a | b) == 8'd0, 1'b0, 1'b0, 1'b0};
			end
			calu_pkg::ACT_INC: begin
				res.result_value = {8'd0, b + 8'd1};
				res.flags_out = {b == 8'hFF, 1'b0, b[3:0] == 4'hF, cin};
			end
			calu_pkg::ACT_DEC: begin
				res.result_value = {8'd0, b - 8'd1};
				res.flags_out = {b == 8'h01, 1'b1, b[3:0] == 4'h0, cin};
			end
			calu_pkg::ACT_DAA: begin
				res.result_value = {8'd0, daa_r2};
				res.flags_out = {daa_r2 == 8'd0, nin, 1'b0, daa_c};
			end
			calu_pkg::ACT_CPL: begin
				res.result_value = {8'd0, ~a};
				res.flags_out = {zin, 1'b1, 1'b1, cin};
			end
			calu_pkg::ACT_SCF: begin
				res.result_value = {8'd0, a};
				res.flags_out = {zin, 1'b0, 1'b0, 1'b1};
			end
			calu_pkg::ACT_CCF: begin
				res.result_value = {8'd0, a};
				res.flags_out = {zin, 1'b0, 1'b0, !cin};
			end
			calu_pkg::ACT_RLCA: begin
				res.result_value = {8'd0, a[6:0], a[7]};
				res.flags_out = {3'b000, a[7]};
			end
			calu_pkg::ACT_RRCA: begin
				res.result_value = {8'd0, a[0], a[7:1]};
				res.flags_out = {3'b000, a[0]};
			end
			calu_pkg::ACT_RLA: begin
				res.result_value = {8'd0, a[6:0], cin};
				res.flags_out = {3'b000, a[7]};
			end
			calu_pkg::ACT_RRA: begin
				res.result_value = {8'd0, cin, a[7:1]};
				res.flags_out = {3'b000, a[0]};
			end
			calu_pkg::ACT_RLC, calu_pkg::ACT_RRC, calu_pkg::ACT_RL, calu_pkg::ACT_RR,
			calu_pkg::ACT_SLA, calu_pkg::ACT_SRA, calu_pkg::ACT_SWAP,
			calu_pkg::ACT_SRL: begin
				res.result_value = {8'd0, sh_r};
				res.flags_out = {sh_r == 8'd0, 1'b0, 1'b0, sh_c};
			end
			calu_pkg::ACT_BIT: begin
				res.flags_out = {!b[req.bit_index], 1'b0, 1'b1, cin};
				res.writes_result = 1'b0;
			end
			calu_pkg::ACT_RES: begin
				res.result_value = {8'd0, b & ~bit_mask};
			end
			calu_pkg::ACT_SET: begin
				res.result_value = {8'd0, b | bit_mask};
			end
			calu_pkg::ACT_ADD16: begin
				res.result_value = w_sum[15:0];
				res.flags_out = {zin, 1'b0, w_half[12], w_sum[16]};
			end
			calu_pkg::ACT_ADDSP: begin
				res.result_value = sp_sum;
				res.flags_out = {2'b00, sp_half[4], sp_carry[8]};
			end
			default: begin
				// unused code: no write, flags pass through
				res.writes_result = 1'b0;
			end
		endcase
	end

endmodule

>>> hdl/cpu_8bit_alu_with_flags.sv
// Top level of the 8-bit ALU with flags: input register, datapath, result register.
// Depends on calu_pkg and calu_core.
//
//   channel | direction | handshake               | payload
//   in      | into ALU  | in_valid / in_stall     | action, accumulator, operand,
//           |           |                         | base_word, bit_index, flags_in
//   out     | from ALU  | out_valid / out_stall   | result_value, flags_out, writes_result
//
// An accepted beat is registered in the input register; the datapath between it and the
// result register computes the result, which the result register loads unless out_stall
// holds it; out_valid then rises, and the result is taken at an edge with out_stall low.
// One beat per cycle is sustained while out_stall stays low.
// Reset empties both registers; no beat is pending after arst_n rises.
// out_stall holds the result register; in_stall rises only when both stages are full and out_stall is high.

module cpu_8bit_alu_with_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  action,
	input  logic [7:0]  accumulator,
	input  logic [15:0] operand,
	input  logic [15:0] base_word,
	input  logic [2:0]  bit_index,
	input  logic [3:0]  flags_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] result_value,
	output logic [3:0]  flags_out,
	output logic        writes_result
);

	calu_pkg::alu_req_t req_s1;
	calu_pkg::alu_res_t res_comb;
	calu_pkg::alu_res_t res_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               adv_s1;
	logic               adv_s2;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			req_s1 <= '{action: action, accumulator: accumulator, operand: operand,
				base_word: base_word, bit_index: bit_index, flags_in: flags_in};
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	calu_core u_core (
		.req (req_s1),
		.res (res_comb)
	);

	assign out_valid     = valid_s2;
	assign result_value  = res_s2.result_value;
	assign flags_out     = res_s2.flags_out;
	assign writes_result = res_s2.writes_result;

	// a stalled input beat means stage 1 is already holding one
	a_stall_has_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> valid_s1)
		else $error("input stalled with empty stage 1");

	// stage 1 drains into the result register unless the output is held
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !(valid_s2 && out_stall) |=> out_valid)
		else $error("stage 1 beat lost");

	// accepted beat lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted beat not registered");

	// no-write results carry a zero value
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !writes_result |-> result_value == 16'd0)
		else $error("no-write result with nonzero value");

endmodule
